// ----- hw/rtl/lwmr_pkg.sv -----
// Shared types and constants for the merged-weight reorder address generator.
// No dependencies.
package lwmr_pkg;

    localparam int CFG_W  = 11;  // widest configuration register
    localparam int IDX_W  = 2;   // configuration register index
    localparam int OFS_W  = 24;  // destination offset width
    localparam int WORD_W = 32;  // weight word port width

    localparam logic [IDX_W-1:0] CFG_DIR_COUNT    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_INPUT_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_HIDDEN_WIDTH = 2'd2;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [OFS_W-1:0]  base_part;  // block base + gate offset
        logic [OFS_W-1:0]  pos_part;   // column stride sum + row
        logic              last;
    } t_item;

endpackage

// ----- hw/rtl/lwmr_front.sv -----
// Front end: configuration registers, nested position counters and the
// incremental offset terms. Depends on lwmr_pkg.
module lwmr_front #(
    parameter int MAX_DIM   = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lwmr_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [lwmr_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    input  logic [lwmr_pkg::WORD_W-1:0] i_word,
    input  logic                        i_space,
    output logic                        o_push,
    output lwmr_pkg::t_item             o_item
);
    import lwmr_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam logic [WORD_W-1:0] WORD_MASK = (WORD_BITS >= WORD_W) ? '1 :
        WORD_W'((64'd1 << WORD_BITS) - 64'd1);

    logic [1:0]       r_dir_count;
    logic [CFG_W-1:0] r_input_width;
    logic [CFG_W-1:0] r_hidden_width;

    logic             r_dir;
    logic             r_rec;
    logic [1:0]       r_gate;
    logic [DIM_W-1:0] r_row;
    logic [DIM_W-1:0] r_col;
    logic [OFS_W-1:0] r_block_base;
    logic [OFS_W-1:0] r_gate_off;
    logic [OFS_W-1:0] r_col_acc;

    logic [DIM_W-1:0] iw, hw, cols;
    logic [CMP_W-1:0] iw_ext, hw_ext;
    logic [OFS_W-1:0] h1, h2, h4, n_gate_off;
    logic             dir_last, col_end, row_end, gate_end, cfg_hit;

    always_comb begin
        iw_ext = CMP_W'(r_input_width);
        hw_ext = CMP_W'(r_hidden_width);
        if (iw_ext == '0) begin
            iw = DIM_W'(1);
        end else if (iw_ext > CMP_W'(MAX_DIM)) begin
            iw = DIM_W'(MAX_DIM);
        end else begin
            iw = DIM_W'(iw_ext);
        end
        if (hw_ext == '0) begin
            hw = DIM_W'(1);
        end else if (hw_ext > CMP_W'(MAX_DIM)) begin
            hw = DIM_W'(MAX_DIM);
        end else begin
            hw = DIM_W'(hw_ext);
        end
    end

    assign cols     = r_rec ? hw : iw;
    assign h1       = OFS_W'(hw);
    assign h2       = h1 << 1;
    assign h4       = h1 << 2;
    assign dir_last = (r_dir == r_dir_count[1]);  // 0 or 1 -> one dir, 2 or 3 -> two
    // cols and hw are never below one
    assign col_end  = (r_col == cols - DIM_W'(1));
    assign row_end  = (r_row == hw - DIM_W'(1));
    assign gate_end = (r_gate == 2'd3);
    assign cfg_hit  = i_cfg_we &&
                      (i_cfg_index inside {CFG_DIR_COUNT, CFG_INPUT_WIDTH, CFG_HIDDEN_WIDTH});

    // Destination gate order after swapping source gates 1 and 2: 0, 2H, H, 3H.
    always_comb begin
        case (r_gate)
            2'd0:    n_gate_off = h2;
            2'd1:    n_gate_off = h1;
            2'd2:    n_gate_off = r_gate_off + h2;
            default: n_gate_off = '0;
        endcase
    end

    assign o_push           = i_valid && i_space;
    assign o_item.word      = i_word & WORD_MASK;
    assign o_item.base_part = r_block_base + r_gate_off;
    assign o_item.pos_part  = r_col_acc + OFS_W'(r_row);
    assign o_item.last      = dir_last && r_rec && gate_end && row_end && col_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_count    <= 2'd1;
            r_input_width  <= CFG_W'(1);
            r_hidden_width <= CFG_W'(1);
            r_dir          <= 1'b0;
            r_rec          <= 1'b0;
            r_gate         <= '0;
            r_row          <= '0;
            r_col          <= '0;
            r_block_base   <= '0;
            r_gate_off     <= '0;
            r_col_acc      <= '0;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                CFG_DIR_COUNT:   r_dir_count    <= i_cfg_data[1:0];
                CFG_INPUT_WIDTH: r_input_width  <= i_cfg_data;
                default:         r_hidden_width <= i_cfg_data;
            endcase
            r_dir        <= 1'b0;
            r_rec        <= 1'b0;
            r_gate       <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_block_base <= '0;
            r_gate_off   <= '0;
            r_col_acc    <= '0;
        end else if (o_push) begin
            if (!col_end) begin
                r_col     <= r_col + DIM_W'(1);
                r_col_acc <= r_col_acc + h4;
            end else begin
                r_col     <= '0;
                r_col_acc <= '0;
                if (!row_end) begin
                    r_row <= r_row + DIM_W'(1);
                end else begin
                    r_row <= '0;
                    if (!gate_end) begin
                        r_gate     <= r_gate + 2'd1;
                        r_gate_off <= n_gate_off;
                    end else begin
                        r_gate     <= '0;
                        r_gate_off <= '0;
                        // col_acc + 4H here is the size of the block just finished
                        if (!r_rec) begin
                            r_rec        <= 1'b1;
                            r_block_base <= r_block_base + r_col_acc + h4;
                        end else begin
                            r_rec <= 1'b0;
                            if (dir_last) begin
                                r_dir        <= 1'b0;
                                r_block_base <= '0;
                            end else begin
                                r_dir        <= 1'b1;
                                r_block_base <= r_block_base + r_col_acc + h4;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- hw/rtl/lwmr_fifo.sv -----
// Two-entry queue between the front and back ends.
// Depends on lwmr_pkg.
module lwmr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lwmr_pkg::t_item i_item,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_pop,
    output lwmr_pkg::t_item o_item
);
    import lwmr_pkg::*;

    localparam int DEPTH = 2;

    t_item      r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_space = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- hw/rtl/lwmr_back.sv -----
// Back end: final offset add and the output register stage.
// Depends on lwmr_pkg.
module lwmr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  lwmr_pkg::t_item             i_q_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lwmr_pkg::OFS_W-1:0]  o_dest_offset,
    output logic [lwmr_pkg::WORD_W-1:0] o_dest_word,
    output logic                        o_final_word
);
    import lwmr_pkg::*;

    logic              r_valid;
    logic [OFS_W-1:0]  r_dest_ofs;
    logic [WORD_W-1:0] r_word;
    logic              r_last;

    assign o_pop         = i_q_valid && (!r_valid || i_ready);
    assign o_valid       = r_valid;
    assign o_dest_offset = r_dest_ofs;
    assign o_dest_word   = r_word;
    assign o_final_word  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dest_ofs <= i_q_item.base_part + i_q_item.pos_part;
            r_word     <= i_q_item.word;
            r_last     <= i_q_item.last;
        end
    end

endmodule

// ----- hw/rtl/lstm_weight_merge_reorder.sv -----
// Top level of the merged recurrent-weight reorder address generator.
// Depends on lwmr_pkg, lwmr_front, lwmr_fifo and lwmr_back.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one 32-bit weight word per
//    request, in source order: per direction the input block, then the
//    recurrence block, each gate-major, then row, then column.
//  - Output channel (o_out_valid / i_out_ready): destination offset in the
//    merged buffer, the word itself (masked to WORD_BITS), and a flag on the
//    last word of the whole transfer. Gates 1 and 2 are swapped (ifog order).
//  - Config port: i_cfg_we / i_cfg_index / i_cfg_data writes direction_count,
//    input_width or hidden_width. Any valid write restarts the transfer.
//    Write only while the block is empty.
//  - Throughput: one request per cycle while the queue has space, set by
//    the counter/stride-adder loop in the front end. Path: an accepted
//    request is written into the queue and moves on into the output
//    register when it is free or drained (front -> queue -> output register).
//  - Stall: the two-entry queue plus the output register absorb backpressure;
//    o_in_ready drops only when the queue is full. No clearing pass.
//  - Reset (synchronous, active low): registers go to 1, counters to the
//    start of a transfer, queue and output empty.
module lstm_weight_merge_reorder #(
    parameter int MAX_DIM   = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [lwmr_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [lwmr_pkg::CFG_W-1:0]  i_cfg_data,
    // input requests
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lwmr_pkg::WORD_W-1:0] i_weight_word,
    // output requests
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lwmr_pkg::OFS_W-1:0]  o_dest_offset,
    output logic [lwmr_pkg::WORD_W-1:0] o_dest_word,
    output logic                        o_final_word
);
    import lwmr_pkg::*;

    logic  q_space;
    logic  q_valid;
    logic  push;
    logic  pop;
    t_item front_item;
    t_item q_item;

    assign o_in_ready = q_space;

    // Front: counters track direction/block/gate/row/column and keep the
    // offset as running sums, so no multiplier is needed.
    lwmr_front #(
        .MAX_DIM   (MAX_DIM),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .i_word      (i_weight_word),
        .i_space     (q_space),
        .o_push      (push),
        .o_item      (front_item)
    );

    // Decoupling queue.
    lwmr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_space (q_space),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    // Back: final add of the two offset halves into the output register.
    lwmr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_dest_offset (o_dest_offset),
        .o_dest_word   (o_dest_word),
        .o_final_word  (o_final_word)
    );

    // Queue never takes a request while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_space)
        else $error("request pushed into full queue");

    // Output stage comes up empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A queued request moves into an empty output stage on the next cycle.
    a_back_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !o_out_valid) |=> o_out_valid)
        else $error("back end failed to load a queued request");

endmodule
